/* hdl/qbt_pkg.sv */
// Package with the shared types and constants of the curve tessellator.
package qbt_pkg;

  localparam int unsigned CoordBits   = 24;
  localparam int unsigned CtrlBits    = 26;
  localparam int unsigned CountBits   = 6;
  localparam int unsigned MaxSegments = 63;

  localparam int unsigned QuoBits   = 25;
  localparam int unsigned MagBits   = 38;
  localparam int unsigned EvalDepth = QuoBits + 5;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [CtrlBits-1:0]  ctrl_t;

  typedef struct packed {
    logic [CountBits-1:0] n;
    logic [CountBits-1:0] i;
    logic                 last;
  } idx_t;

  typedef struct packed {
    logic    valid;
    idx_t    idx;
    coord_t  p0x;
    coord_t  p0y;
    ctrl_t   p1x;
    ctrl_t   p1y;
    coord_t  p2x;
    coord_t  p2y;
  } issue_t;

endpackage

/* hdl/qbt_seq.sv */
// Point sequencer: holds one curve and steps the point index.
module qbt_seq #(
  parameter int unsigned MaxSeg = qbt_pkg::MaxSegments
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [23:0]            start_x_i,
  input  logic signed [23:0]            start_y_i,
  input  logic signed [23:0]            ctrl_x_i,
  input  logic signed [23:0]            ctrl_y_i,
  input  logic signed [23:0]            end_x_i,
  input  logic signed [23:0]            end_y_i,
  input  logic [5:0]                    segment_count_i,
  input  logic                          through_ctrl_i,
  output logic                          busy_o,
  output qbt_pkg::issue_t               issue_o
);

  logic                 act_q, act_d;
  logic [5:0]           n_q, i_q, n_c;
  qbt_pkg::coord_t      p0x_q, p0y_q, p2x_q, p2y_q;
  qbt_pkg::ctrl_t       p1x_q, p1y_q, p1x_c, p1y_c;
  logic signed [24:0]   sx_c, sy_c;
  logic                 take;

  assign take = start_i && !act_q && (segment_count_i != '0);
  assign n_c  = (segment_count_i > 6'(MaxSeg)) ? 6'(MaxSeg) : segment_count_i;
  assign sx_c = 25'(start_x_i) + 25'(end_x_i);
  assign sy_c = 25'(start_y_i) + 25'(end_y_i);
  assign p1x_c = through_ctrl_i ? (26'(ctrl_x_i) <<< 1) - 26'(sx_c >>> 1) : 26'(ctrl_x_i);
  assign p1y_c = through_ctrl_i ? (26'(ctrl_y_i) <<< 1) - 26'(sy_c >>> 1) : 26'(ctrl_y_i);

  always_comb begin
    act_d = act_q;
    if (take) begin
      act_d = 1'b1;
    end else if (act_q && (i_q == n_q)) begin
      act_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      i_q   <= '0;
    end else begin
      act_q <= act_d;
      if (take) begin
        i_q <= '0;
      end else if (act_q) begin
        i_q <= i_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      n_q   <= n_c;
      p0x_q <= start_x_i;
      p0y_q <= start_y_i;
      p1x_q <= p1x_c;
      p1y_q <= p1y_c;
      p2x_q <= end_x_i;
      p2y_q <= end_y_i;
    end
  end

  assign busy_o = act_q;

  always_comb begin
    issue_o.valid    = act_q;
    issue_o.idx.n    = n_q;
    issue_o.idx.i    = i_q;
    issue_o.idx.last = (i_q == n_q);
    issue_o.p0x      = p0x_q;
    issue_o.p0y      = p0y_q;
    issue_o.p1x      = p1x_q;
    issue_o.p1y      = p1y_q;
    issue_o.p2x      = p2x_q;
    issue_o.p2y      = p2y_q;
  end

endmodule

/* hdl/qbt_eval.sv */
// Pipelined evaluation of one coordinate: weights, weighted sum, rounded divide, saturation.
module qbt_eval (
  input  logic                 clk_i,
  input  logic [5:0]           n_i,
  input  logic [5:0]           i_i,
  input  qbt_pkg::coord_t      p0_i,
  input  qbt_pkg::ctrl_t       p1_i,
  input  qbt_pkg::coord_t      p2_i,
  output qbt_pkg::coord_t      pt_o
);

  localparam int unsigned QuoBits = qbt_pkg::QuoBits;
  localparam int unsigned MagBits = qbt_pkg::MagBits;
  localparam logic signed [QuoBits:0] QMax = (QuoBits+1)'(8388607);
  localparam logic signed [QuoBits:0] QMin = (QuoBits+1)'(-8388608);

  // Stage 1: weights.
  logic [11:0]          w0_q, w1_q, w2_q, d_q;
  qbt_pkg::coord_t      p0_q, p2_q;
  qbt_pkg::ctrl_t       p1_q;
  logic [5:0]           a_c;

  assign a_c = n_i - i_i;

  always_ff @(posedge clk_i) begin
    w0_q <= 12'(a_c) * 12'(a_c);
    w1_q <= 12'(i_i) * 12'(a_c);
    w2_q <= 12'(i_i) * 12'(i_i);
    d_q  <= 12'(n_i) * 12'(n_i);
    p0_q <= p0_i;
    p1_q <= p1_i;
    p2_q <= p2_i;
  end

  // Stage 2: products.
  logic signed [37:0] m0_q, m1_q, m2_q;
  logic [11:0]        d2_q;

  always_ff @(posedge clk_i) begin
    m0_q <= 38'(p0_q) * 38'($signed({1'b0, w0_q}));
    m1_q <= 38'(p1_q) * 38'($signed({1'b0, w1_q}));
    m2_q <= 38'(p2_q) * 38'($signed({1'b0, w2_q}));
    d2_q <= d_q;
  end

  // Stage 3: numerator 2*num + d, always taken as a floor divide by 2*d.
  logic signed [40:0] t_q;
  logic [12:0]        d3_q;

  always_ff @(posedge clk_i) begin
    t_q  <= (41'(m0_q) <<< 1) + (41'(m1_q) <<< 2) + (41'(m2_q) <<< 1) + 41'($signed({1'b0, d2_q}));
    d3_q <= {d2_q, 1'b0};
  end

  // Stage 4: magnitude, with a negative numerator biased so that the divide floors.
  logic signed [40:0] abs_c;
  logic [MagBits-1:0] rem_q [QuoBits];
  logic [12:0]        div_q [QuoBits];
  logic [QuoBits-1:0] quo_q [QuoBits+1];
  logic               neg_q [QuoBits+1];

  always_comb begin
    abs_c = t_q;
    if (t_q < 0) begin
      abs_c = 41'sd0 - t_q + 41'($signed({1'b0, d3_q})) - 41'sd1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= abs_c[MagBits-1:0];
    div_q[0] <= d3_q;
    quo_q[0] <= '0;
    neg_q[0] <= t_q[40];
  end

  // Restoring divider, one quotient bit per stage, most significant bit first.
  for (genvar s = 0; s < QuoBits; s++) begin : g_div
    localparam int unsigned Sh = QuoBits - 1 - s;
    logic [MagBits-1:0] sub_c;
    logic               ge_c;

    assign sub_c = MagBits'(div_q[s]) << Sh;
    assign ge_c  = (rem_q[s] >= sub_c);

    always_ff @(posedge clk_i) begin
      quo_q[s+1] <= quo_q[s] | (QuoBits'(ge_c) << Sh);
      neg_q[s+1] <= neg_q[s];
    end

    if (s < QuoBits - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        rem_q[s+1] <= ge_c ? rem_q[s] - sub_c : rem_q[s];
        div_q[s+1] <= div_q[s];
      end
    end
  end

  // Final stage: sign and saturation.
  logic signed [QuoBits:0] q_c;

  assign q_c = neg_q[QuoBits] ? -$signed({1'b0, quo_q[QuoBits]})
                              : $signed({1'b0, quo_q[QuoBits]});

  always_ff @(posedge clk_i) begin
    if (q_c > QMax) begin
      pt_o <= 24'sh7FFFFF;
    end else if (q_c < QMin) begin
      pt_o <= 24'sh800000;
    end else begin
      pt_o <= q_c[qbt_pkg::CoordBits-1:0];
    end
  end

endmodule

/* hdl/quadratic_bezier_tessellator_unit.sv */
// Quadratic curve tessellator top level: sequencer, two evaluators and strobe delay line.
// Each point's strobe and last flag travel down the delay line in step with its evaluation.
// Throughput: one point per cycle while busy; busy stays high while a curve's points issue,
// and a new curve is taken only once busy is low; a curve of zero segments is not taken.
// The rate is set by the single point index counter feeding the thirty-stage evaluators.
// Reset clears the sequencer and the strobe delay line; data registers are not reset.
// The receiver cannot stall, so points leave at a fixed cadence.
module quadratic_bezier_tessellator_unit #(
  parameter int unsigned MaxSeg = qbt_pkg::MaxSegments
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] start_x_i,
  input  logic signed [23:0] start_y_i,
  input  logic signed [23:0] ctrl_x_i,
  input  logic signed [23:0] ctrl_y_i,
  input  logic signed [23:0] end_x_i,
  input  logic signed [23:0] end_y_i,
  input  logic [5:0]         segment_count_i,
  input  logic               through_ctrl_i,
  output logic               strobe,
  output logic signed [23:0] point_x_o,
  output logic signed [23:0] point_y_o,
  output logic               last_point_o
);

  localparam int unsigned Depth = qbt_pkg::EvalDepth;

  qbt_pkg::issue_t   iss;
  logic [Depth-1:0]  vld_q;
  logic [Depth-1:0]  lst_q;

  qbt_seq #(.MaxSeg(MaxSeg)) u_seq (
    .clk_i, .rst_ni, .start_i(start),
    .start_x_i, .start_y_i, .ctrl_x_i, .ctrl_y_i, .end_x_i, .end_y_i,
    .segment_count_i, .through_ctrl_i,
    .busy_o(busy), .issue_o(iss)
  );

  qbt_eval u_ex (
    .clk_i, .n_i(iss.idx.n), .i_i(iss.idx.i),
    .p0_i(iss.p0x), .p1_i(iss.p1x), .p2_i(iss.p2x), .pt_o(point_x_o)
  );

  qbt_eval u_ey (
    .clk_i, .n_i(iss.idx.n), .i_i(iss.idx.i),
    .p0_i(iss.p0y), .p1_i(iss.p1y), .p2_i(iss.p2y), .pt_o(point_y_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      lst_q <= '0;
    end else begin
      vld_q <= {vld_q[Depth-2:0], iss.valid};
      lst_q <= {lst_q[Depth-2:0], iss.valid && iss.idx.last};
    end
  end

  assign strobe       = vld_q[Depth-1];
  assign last_point_o = lst_q[Depth-1];

  a_last_has_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_point_o |-> strobe) else $error("last point without strobe");
  a_last_in_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (iss.valid && iss.idx.last) |=> !busy) else $error("busy after last issue");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> ($past(iss.idx.i) + 6'd1 == iss.idx.i) || !busy) else $error("index skip");

endmodule

/* sim/quadratic_bezier_tessellator_unit_checker.sv */
// Checker that predicts the curve points of each accepted transfer and compares the strobed points.
module quadratic_bezier_tessellator_unit_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic signed [23:0] start_x_i,
  input  logic signed [23:0] start_y_i,
  input  logic signed [23:0] ctrl_x_i,
  input  logic signed [23:0] ctrl_y_i,
  input  logic signed [23:0] end_x_i,
  input  logic signed [23:0] end_y_i,
  input  logic [5:0]         segment_count_i,
  input  logic               through_ctrl_i,
  input  logic               strobe_i,
  input  logic signed [23:0] point_x_i,
  input  logic signed [23:0] point_y_i,
  input  logic               last_point_i,
  output int                 fail_count_o,
  output logic               drained_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    qbt_pkg::coord_t x;
    qbt_pkg::coord_t y;
    logic            last;
  } curve_point_t;

  curve_point_t pending_points[$];
  int           fail_cnt = 0;

  assign drained_o    = (pending_points.size() == 0);
  assign fail_count_o = fail_cnt;

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic qbt_pkg::coord_t bezier_coord(longint p0, longint p1, longint p2,
                                                   longint n, longint i);
    longint a;
    longint d;
    longint num;
    longint v;
    a = n - i;
    d = n * n;
    num = a * a * p0 + 2 * i * a * p1 + i * i * p2;
    v = floor_quot(2 * num + d, 2 * d);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return qbt_pkg::coord_t'(v);
  endfunction

  task automatic tessellate_curve();
    longint sx, sy, cx, cy, ex, ey, n;
    curve_point_t pt;
    sx = start_x_i; sy = start_y_i; cx = ctrl_x_i; cy = ctrl_y_i;
    ex = end_x_i; ey = end_y_i; n = segment_count_i;
    if (n > qbt_pkg::MaxSegments) n = qbt_pkg::MaxSegments;
    if (through_ctrl_i) begin
      cx = 2 * cx - floor_quot(sx + ex, 2);
      cy = 2 * cy - floor_quot(sy + ey, 2);
    end
    for (longint i = 0; i <= n && n != 0; i++) begin
      pt.x = bezier_coord(sx, cx, ex, n, i);
      pt.y = bezier_coord(sy, cy, ey, n, i);
      pt.last = (i == n);
      pending_points = {pending_points, pt};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    curve_point_t exp_pt;
    if (rst_ni) begin
      if (start_i && !busy_i) tessellate_curve();
      if (strobe_i) begin
        if (pending_points.size() == 0) begin
          $error("Point strobed with none expected: x %0d y %0d", point_x_i, point_y_i);
          fail_cnt++;
        end else begin
          exp_pt = pending_points.pop_front();
          if (point_x_i !== exp_pt.x) begin
            $error("point_x expected %0d actual %0d", exp_pt.x, point_x_i);
            fail_cnt++;
          end
          if (point_y_i !== exp_pt.y) begin
            $error("point_y expected %0d actual %0d", exp_pt.y, point_y_i);
            fail_cnt++;
          end
          if (last_point_i !== exp_pt.last) begin
            $error("last_point expected %0b actual %0b", exp_pt.last, last_point_i);
            fail_cnt++;
          end
        end
      end
    end
  end

endmodule

/* sim/quadratic_bezier_tessellator_unit_tb.sv */
// Testbench top that drives curve transfers into the tessellator and reports the verdict.
module quadratic_bezier_tessellator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 2000000;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [23:0] start_x_i, start_y_i, ctrl_x_i, ctrl_y_i, end_x_i, end_y_i;
  logic [5:0]         segment_count_i;
  logic               through_ctrl_i;
  logic               strobe;
  logic signed [23:0] point_x_o, point_y_o;
  logic               last_point_o;
  int                 fail_count;
  logic               drained;
  int                 sender_idle_pct;
  int unsigned        cycle_count;

  quadratic_bezier_tessellator_unit DUT (.*);

  quadratic_bezier_tessellator_unit_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy),
    .start_x_i, .start_y_i, .ctrl_x_i, .ctrl_y_i, .end_x_i, .end_y_i,
    .segment_count_i, .through_ctrl_i, .strobe_i(strobe),
    .point_x_i(point_x_o), .point_y_i(point_y_o), .last_point_i(last_point_o),
    .fail_count_o(fail_count), .drained_o(drained)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_curve(int sx, int sy, int cx, int cy, int ex, int ey,
                            int unsigned n, bit thru);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    start_x_i <= 24'(sx); start_y_i <= 24'(sy);
    ctrl_x_i <= 24'(cx); ctrl_y_i <= 24'(cy);
    end_x_i <= 24'(ex); end_y_i <= 24'(ey);
    segment_count_i <= 6'(n);
    through_ctrl_i <= thru;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
  endtask

  function automatic int rand_coord();
    case ($urandom_range(3))
      0: return $signed(24'($urandom));
      1: return int'($urandom_range(2000)) - 1000;
      2: return $urandom_range(1) ? 8388607 - int'($urandom_range(50))
                                  : -8388608 + int'($urandom_range(50));
      default: return int'($urandom_range(200000)) - 100000;
    endcase
  endfunction

  function automatic int unsigned rand_count();
    if ($urandom_range(19) == 0) return $urandom_range(63);
    return $urandom_range(8);
  endfunction

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    start_x_i <= '0; start_y_i <= '0; ctrl_x_i <= '0; ctrl_y_i <= '0;
    end_x_i <= '0; end_y_i <= '0;
    segment_count_i <= '0;
    through_ctrl_i <= 1'b0;
    sender_idle_pct = 8;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_curve(0, 0, 0, 0, 0, 0, 1, 0);
    send_curve(100, 200, 300, 400, 500, 600, 0, 1);
    send_curve(8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 63, 0);
    send_curve(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608, 63, 1);
    send_curve(-8388608, 8388607, 8388607, -8388608, -8388608, 8388607, 5, 1);
    send_curve(-8388608, -8388608, 8388607, 8388607, -8388608, -8388608, 7, 1);
    send_curve(8388607, -8388608, -8388608, 8388607, 8388607, -8388608, 2, 1);
    send_curve(-1, -3, 1, -1, -2, 3, 2, 1);
    send_curve(-7, 5, 3, -9, 11, -13, 3, 0);
    send_curve(-8388608, 8388607, 0, 0, 8388607, -8388608, 63, 0);
    send_curve(1, -1, 0, 0, 0, 1, 4, 1);
    send_curve(256, -256, 512, -512, 768, -768, 1, 1);
    send_curve(12345, -54321, -8388608, 8388607, 999, -999, 63, 1);
    send_curve(3, 3, 3, 3, 3, 3, 0, 0);

    for (int k = 0; k < 450; k++) begin
      if (k == 150) sender_idle_pct = 57;
      if (k == 300) sender_idle_pct = 0;
      send_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_count(), 1'($urandom_range(1)));
    end
    start <= 1'b0;

    while (!drained) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
